[rtl/core/ssm_pkg.sv]
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types, constants and the character-to-segment table for the
// multiplexed scrolling 7-segment display driver.
// ----------------------------------------------------------------------------
package ssm_pkg;

	localparam int MAX_TEXT     = 64;
	localparam int PAD          = 6;
	localparam int SCROLL_TICKS = 64;

	localparam int HALF_PAD = PAD / 2;
	localparam int ADDR_W   = $clog2(MAX_TEXT);
	localparam int LEN_W    = $clog2(MAX_TEXT);
	localparam int POS_W    = $clog2(MAX_TEXT + PAD + 4);
	localparam int TIMER_W  = $clog2(SCROLL_TICKS);

	typedef enum logic [2:0] {
		FUNC_TICK       = 3'd0,
		FUNC_LOAD_STAND = 3'd1,
		FUNC_STOP_STAND = 3'd2,
		FUNC_WRITE_CHAR = 3'd3,
		FUNC_START_ROLL = 3'd4,
		FUNC_STOP_REP   = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_BUSY  = 2'd1,
		ST_ERROR = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0]  func;
		logic [7:0]  char_code;
		logic [5:0]  char_index;
		logic [31:0] standing_text;
		logic [6:0]  text_length;
		logic        repeat_forever;
	} item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] segments;
		logic [3:0] anodes;
		logic       rolling_busy;
		logic       standing_busy;
	} result_t;

	typedef struct packed {
		logic [1:0] status;
		logic       show_text;
		logic       show_stand;
		logic [7:0] stand_char;
		logic [3:0] anodes;
		logic       rolling_busy;
		logic       standing_busy;
	} s1_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [7:0]        wr_data;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} mem_req_t;

	function automatic logic [7:0] encode(input logic [7:0] c);
		logic [7:0] seg;
		unique case (c)
			8'h30: seg = 8'h3F;
			8'h31: seg = 8'h06;
			8'h32: seg = 8'h5B;
			8'h33: seg = 8'h4F;
			8'h34: seg = 8'h66;
			8'h35: seg = 8'h6D;
			8'h36: seg = 8'h7D;
			8'h37: seg = 8'h07;
			8'h38: seg = 8'h7F;
			8'h39: seg = 8'h6F;
			8'h41, 8'h61: seg = 8'h77;
			8'h42, 8'h62: seg = 8'h7C;
			8'h43, 8'h63: seg = 8'h39;
			8'h44, 8'h64: seg = 8'h5E;
			8'h45, 8'h65: seg = 8'h79;
			8'h46, 8'h66: seg = 8'h71;
			8'h47, 8'h67: seg = 8'h3D;
			8'h48, 8'h68: seg = 8'h74;
			8'h49, 8'h69: seg = 8'h30;
			8'h4A, 8'h6A: seg = 8'h1E;
			8'h4B, 8'h6B: seg = 8'h75;
			8'h4C, 8'h6C: seg = 8'h38;
			8'h4D, 8'h6D: seg = 8'h55;
			8'h4E, 8'h6E: seg = 8'h54;
			8'h4F, 8'h6F: seg = 8'h5C;
			8'h50, 8'h70: seg = 8'h73;
			8'h51, 8'h71: seg = 8'h67;
			8'h52, 8'h72: seg = 8'h50;
			8'h53, 8'h73: seg = 8'h6D;
			8'h54, 8'h74: seg = 8'h78;
			8'h55, 8'h75: seg = 8'h3E;
			8'h56, 8'h76: seg = 8'h1C;
			8'h57, 8'h77: seg = 8'h6A;
			8'h58, 8'h78: seg = 8'h76;
			8'h59, 8'h79: seg = 8'h6E;
			8'h5A, 8'h7A: seg = 8'h5B;
			8'h2E: seg = 8'h80;
			8'h2D: seg = 8'h40;
			8'h3E: seg = 8'h4C;
			8'h3C: seg = 8'h58;
			8'h2A: seg = 8'h63;
			default: seg = 8'h00;
		endcase
		return seg;
	endfunction

endpackage

[rtl/core/ssm_text_mem.sv]
// ----------------------------------------------------------------------------
// ssm_text_mem
// Rolling text store: one write port, one registered read port, with a
// valid bit per entry so that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module ssm_text_mem (
	input  logic             clk,
	input  logic             arst_n,
	input  ssm_pkg::mem_req_t req,
	output logic [7:0]       rd_data
);
	import ssm_pkg::*;

	logic [7:0]          mem [MAX_TEXT];
	logic [MAX_TEXT-1:0] vld_q;
	logic [7:0]          data_q;
	logic                hit_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			data_q <= mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				hit_q <= vld_q[req.rd_addr];
			end
		end
	end

	assign rd_data = hit_q ? data_q : 8'h00;

endmodule

[rtl/core/ssm_ctrl.sv]
// ----------------------------------------------------------------------------
// ssm_ctrl
// Command decode and display state: standing/rolling mode, digit scan,
// scroll position and timer. Loads the stage-one register per beat.
// ----------------------------------------------------------------------------
module ssm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  ssm_pkg::item_t    item,
	output ssm_pkg::mem_req_t mem_req,
	output ssm_pkg::s1_t      s1
);
	import ssm_pkg::*;

	logic               rolling_q;
	logic               standing_q;
	logic               repeat_q;
	logic [LEN_W-1:0]   text_len_q;
	logic [POS_W-1:0]   pos_q;
	logic [1:0]         digit_q;
	logic [TIMER_W-1:0] timer_q;
	logic [31:0]        stand_chars_q;
	s1_t                s1_s1;

	logic               rolling_d;
	logic               standing_d;
	logic               repeat_d;
	logic [LEN_W-1:0]   text_len_d;
	logic [POS_W-1:0]   pos_d;
	logic [1:0]         digit_d;
	logic [TIMER_W-1:0] timer_d;
	logic [31:0]        stand_chars_d;
	s1_t                s1_d;

	logic [POS_W-1:0]   pix;
	logic [POS_W-1:0]   tix;
	logic [POS_W-1:0]   pos_adv;
	logic               in_text;
	logic [1:0]         digit_nx;

	assign pix      = pos_q + POS_W'(digit_q);
	assign tix      = pix - POS_W'(HALF_PAD);
	assign in_text  = (pix >= POS_W'(HALF_PAD)) && (tix < POS_W'(text_len_q));
	assign digit_nx = digit_q + 2'd1;
	assign pos_adv  = pos_q + POS_W'(timer_q == '0);

	always_comb begin
		rolling_d     = rolling_q;
		standing_d    = standing_q;
		repeat_d      = repeat_q;
		text_len_d    = text_len_q;
		pos_d         = pos_q;
		digit_d       = digit_q;
		timer_d       = timer_q;
		stand_chars_d = stand_chars_q;
		s1_d          = '0;
		mem_req       = '0;
		s1_d.status   = ST_OK;
		mem_req.rd_addr = ADDR_W'(tix);

		unique case (item.func)
			FUNC_TICK: begin
				if (rolling_q) begin
					s1_d.show_text = in_text;
					s1_d.anodes    = 4'd1 << digit_q;
					mem_req.rd_en  = accept && in_text;
					digit_d        = digit_nx;
					timer_d        = (timer_q == TIMER_W'(SCROLL_TICKS - 1)) ?
						'0 : timer_q + TIMER_W'(1);
					pos_d          = pos_adv;
					if (pos_adv == POS_W'(text_len_q) + POS_W'(PAD)) begin
						if (repeat_q) begin
							pos_d = '0;
						end else begin
							rolling_d = 1'b0;
						end
					end
				end else if (standing_q) begin
					digit_d         = digit_nx;
					s1_d.show_stand = 1'b1;
					s1_d.stand_char = stand_chars_q[8*digit_nx +: 8];
					s1_d.anodes     = 4'd1 << digit_nx;
				end
			end
			FUNC_LOAD_STAND: begin
				if (rolling_q) begin
					s1_d.status = ST_BUSY;
				end else begin
					if (!standing_q) begin
						digit_d = '0;
					end
					standing_d    = 1'b1;
					stand_chars_d = item.standing_text;
				end
			end
			FUNC_STOP_STAND: begin
				if (!standing_q) begin
					s1_d.status = ST_ERROR;
				end else begin
					standing_d = 1'b0;
				end
			end
			FUNC_WRITE_CHAR: begin
				if (rolling_q) begin
					s1_d.status = ST_BUSY;
				end else if (int'(item.char_index) >= MAX_TEXT) begin
					s1_d.status = ST_ERROR;
				end else begin
					mem_req.wr_en   = accept;
					mem_req.wr_addr = ADDR_W'(item.char_index);
					mem_req.wr_data = item.char_code;
				end
			end
			FUNC_START_ROLL: begin
				if (item.repeat_forever) begin
					repeat_d = 1'b1;
				end
				if (rolling_q || standing_q) begin
					s1_d.status = ST_BUSY;
				end else if (int'(item.text_length) >= MAX_TEXT) begin
					s1_d.status = ST_ERROR;
				end else begin
					rolling_d  = 1'b1;
					text_len_d = LEN_W'(item.text_length);
					pos_d      = '0;
					digit_d    = '0;
					timer_d    = TIMER_W'(1);
				end
			end
			FUNC_STOP_REP: begin
				repeat_d = 1'b0;
			end
			default: begin
				s1_d.status = ST_ERROR;
			end
		endcase

		s1_d.rolling_busy  = rolling_d;
		s1_d.standing_busy = standing_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rolling_q     <= 1'b0;
			standing_q    <= 1'b0;
			repeat_q      <= 1'b0;
			text_len_q    <= '0;
			pos_q         <= '0;
			digit_q       <= '0;
			timer_q       <= '0;
			stand_chars_q <= '0;
		end else if (accept) begin
			rolling_q     <= rolling_d;
			standing_q    <= standing_d;
			repeat_q      <= repeat_d;
			text_len_q    <= text_len_d;
			pos_q         <= pos_d;
			digit_q       <= digit_d;
			timer_q       <= timer_d;
			stand_chars_q <= stand_chars_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_s1 <= s1_d;
		end
	end

	assign s1 = s1_s1;

endmodule

[rtl/core/ssm_out.sv]
// ----------------------------------------------------------------------------
// ssm_out
// Segment encode and result register: picks the text store or standing
// character, maps it to a segment pattern and holds the result beat.
// ----------------------------------------------------------------------------
module ssm_out (
	input  logic             clk,
	input  logic             load,
	input  ssm_pkg::s1_t     s1,
	input  logic [7:0]       text_char,
	output ssm_pkg::result_t result
);
	import ssm_pkg::*;

	result_t res_d;
	result_t res_q;

	always_comb begin
		res_d.status        = s1.status;
		res_d.anodes        = s1.anodes;
		res_d.rolling_busy  = s1.rolling_busy;
		res_d.standing_busy = s1.standing_busy;
		priority if (s1.show_text) begin
			res_d.segments = encode(text_char);
		end else if (s1.show_stand) begin
			res_d.segments = encode(s1.stand_char);
		end else begin
			res_d.segments = 8'h00;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

	assign result = res_q;

endmodule

[rtl/core/seven_segment_scroll_multiplexer_top.sv]
// ----------------------------------------------------------------------------
// seven_segment_scroll_multiplexer_top
// Decode loads the stage-one register, then encode loads the result register.
// Throughput: 1 beat per cycle unless stalled; the read port carries one tick.
// Reset: asynchronous, clears modes, scan, scroll state and store valid bits.
// Result beats are held while stall is high; input stalls only if both
// stages are full.
// ----------------------------------------------------------------------------
module seven_segment_scroll_multiplexer_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  ssm_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output ssm_pkg::result_t result
);
	import ssm_pkg::*;

	logic     accept;
	logic     s1_valid_q;
	logic     res_valid_q;
	logic     out_free;
	logic     s1_move;
	mem_req_t mem_req;
	s1_t      s1;
	logic [7:0] text_char;

	assign out_free   = !res_valid_q || !result_stall;
	assign s1_move    = s1_valid_q && out_free;
	assign item_stall = s1_valid_q && !out_free;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			s1_valid_q  <= accept || (s1_valid_q && !s1_move);
			res_valid_q <= s1_move || (res_valid_q && result_stall);
		end
	end

	assign result_valid = res_valid_q;

	ssm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (item),
		.mem_req (mem_req),
		.s1      (s1)
	);

	ssm_text_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (text_char)
	);

	ssm_out u_out (
		.clk       (clk),
		.load      (s1_move),
		.s1        (s1),
		.text_char (text_char),
		.result    (result)
	);

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multiplexed scrolling 7-segment driver. Beats
// go in over a valid/stall channel. A cycle-free predictor of the display
// state computes each expected result beat at acceptance, and a checker
// compares the result channel against it in order. Directed tests cover the
// idle, standing, busy, error, repeat and scroll-end paths, and one long
// hold-off on the result side fills the pipeline. Random traffic then runs
// under four idle/stall mixes.
// ----------------------------------------------------------------------------
module testbench;
	import ssm_pkg::*;

	localparam logic [2:0] FUNC_UNUSED_6 = 3'd6;
	localparam logic [2:0] FUNC_UNUSED_7 = 3'd7;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 80;

	localparam logic [79:0] DIGIT_SEGS = {
		8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
	};
	localparam logic [207:0] LETTER_SEGS = {
		8'h5B, 8'h6E, 8'h76, 8'h6A, 8'h1C, 8'h3E, 8'h78, 8'h6D, 8'h50,
		8'h67, 8'h73, 8'h5C, 8'h54, 8'h55, 8'h38, 8'h75, 8'h1E, 8'h30,
		8'h74, 8'h3D, 8'h71, 8'h79, 8'h5E, 8'h39, 8'h7C, 8'h77
	};
	localparam logic [47:0] PUNCT_CHARS = ".-><* ";

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	seven_segment_scroll_multiplexer_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// display model state
	logic [7:0]  disp_store [MAX_TEXT];
	logic [7:0]  stand_chars [4];
	bit          rolling_on;
	bit          standing_on;
	bit          repeat_on;
	int unsigned roll_len;
	int unsigned roll_pos;
	logic [3:0]  scan_anode;
	int unsigned scan_digit;
	int unsigned scroll_count;

	result_t due_outputs [$];
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;
	int      beats_in = 0;
	int      beats_out = 0;
	int      mismatches = 0;
	int      scrolls_started = 0;
	int      scrolls_ended = 0;
	int      hold_seq = 0;
	int      hold_seen = 0;
	int      hold_left = 0;

	function automatic logic [7:0] seg_pattern(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return DIGIT_SEGS[8 * (c - "0") +: 8];
		if (c >= "A" && c <= "Z")
			return LETTER_SEGS[8 * (c - "A") +: 8];
		if (c >= "a" && c <= "z")
			return LETTER_SEGS[8 * (c - "a") +: 8];
		case (c)
			".": return 8'h80;
			"-": return 8'h40;
			">": return 8'h4C;
			"<": return 8'h58;
			"*": return 8'h63;
			default: return 8'h00;
		endcase
	endfunction

	function automatic void advance_scan();
		scan_anode = (scan_anode == 4'h8) ? 4'h1 : {scan_anode[2:0], 1'b0};
		scan_digit = (scan_digit + 1) % 4;
	endfunction

	function automatic result_t display_next(input item_t it);
		result_t     r;
		int unsigned p;
		r = '0;
		r.status = ST_OK;
		case (it.func)
			FUNC_TICK: begin
				if (rolling_on) begin
					p = roll_pos + scan_digit;
					if (p >= HALF_PAD && p - HALF_PAD < roll_len)
						r.segments = seg_pattern(disp_store[p - HALF_PAD]);
					r.anodes = scan_anode;
					advance_scan();
					if (scroll_count == 0)
						roll_pos++;
					scroll_count = (scroll_count + 1) % SCROLL_TICKS;
					if (roll_pos == roll_len + PAD) begin
						if (repeat_on) begin
							roll_pos = 0;
						end else begin
							rolling_on = 0;
							scrolls_ended++;
						end
					end
				end else if (standing_on) begin
					advance_scan();
					r.segments = seg_pattern(stand_chars[scan_digit]);
					r.anodes = scan_anode;
				end
			end
			FUNC_LOAD_STAND: begin
				if (rolling_on) begin
					r.status = ST_BUSY;
				end else begin
					if (!standing_on) begin
						scan_anode = 4'h1;
						scan_digit = 0;
					end
					standing_on = 1;
					for (int k = 0; k < 4; k++)
						stand_chars[k] = it.standing_text[8 * k +: 8];
				end
			end
			FUNC_STOP_STAND: begin
				if (!standing_on)
					r.status = ST_ERROR;
				else
					standing_on = 0;
			end
			FUNC_WRITE_CHAR: begin
				if (rolling_on)
					r.status = ST_BUSY;
				else if (it.char_index >= MAX_TEXT)
					r.status = ST_ERROR;
				else
					disp_store[it.char_index] = it.char_code;
			end
			FUNC_START_ROLL: begin
				if (it.repeat_forever)
					repeat_on = 1;
				if (rolling_on || standing_on) begin
					r.status = ST_BUSY;
				end else if (it.text_length >= MAX_TEXT) begin
					r.status = ST_ERROR;
				end else begin
					rolling_on = 1;
					roll_len = it.text_length;
					roll_pos = 0;
					scan_anode = 4'h1;
					scan_digit = 0;
					scroll_count = 1 % SCROLL_TICKS;
					scrolls_started++;
				end
			end
			FUNC_STOP_REP: repeat_on = 0;
			default: r.status = ST_ERROR;
		endcase
		r.rolling_busy = rolling_on;
		r.standing_busy = standing_on;
		return r;
	endfunction

	function automatic logic [7:0] pick_char();
		case ($urandom_range(4))
			0: return 8'("0" + $urandom_range(9));
			1: return 8'("A" + $urandom_range(25));
			2: return 8'("a" + $urandom_range(25));
			3: return PUNCT_CHARS[8 * $urandom_range(5) +: 8];
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic item_t make_beat(input logic [2:0] fn);
		item_t b;
		b.func = fn;
		b.char_code = pick_char();
		b.char_index = $urandom_range(1) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
		b.standing_text = {pick_char(), pick_char(), pick_char(), pick_char()};
		b.text_length = 7'($urandom_range(127));
		b.repeat_forever = 1'($urandom_range(1));
		return b;
	endfunction

	task automatic drive_beat(input item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		due_outputs.push_back(display_next(it));
		beats_in++;
	endtask

	task automatic send_ticks(input int n);
		repeat (n)
			drive_beat(make_beat(FUNC_TICK));
	endtask

	task automatic write_char(input int idx, input logic [7:0] code);
		item_t b;
		b = make_beat(FUNC_WRITE_CHAR);
		b.char_index = 6'(idx);
		b.char_code = code;
		drive_beat(b);
	endtask

	task automatic load_standing(input logic [31:0] text);
		item_t b;
		b = make_beat(FUNC_LOAD_STAND);
		b.standing_text = text;
		drive_beat(b);
	endtask

	task automatic start_roll(input int len, input bit rep);
		item_t b;
		b = make_beat(FUNC_START_ROLL);
		b.text_length = 7'(len);
		b.repeat_forever = rep;
		drive_beat(b);
	endtask

	task automatic tick_until_scroll_done();
		while (rolling_on)
			send_ticks(1);
	endtask

	task automatic test_idle_commands();
		send_ticks(2);
		drive_beat(make_beat(FUNC_STOP_STAND));
		drive_beat(make_beat(FUNC_UNUSED_6));
		drive_beat(make_beat(FUNC_UNUSED_7));
		start_roll(MAX_TEXT, 1);
		start_roll(127, 0);
		drive_beat(make_beat(FUNC_STOP_REP));
		write_char(63, 8'hFF);
		write_char(0, 8'h00);
		send_ticks(1);
	endtask

	task automatic test_standing_text();
		load_standing(32'hFFFF_FFFF);
		send_ticks(3);
		load_standing({"Z", "a", ">", "8"});
		send_ticks(5);
		load_standing({"<", "9", ".", "0"});
		start_roll(3, 0);
		send_ticks(2);
		drive_beat(make_beat(FUNC_STOP_STAND));
		send_ticks(1);
		load_standing(32'h0000_0000);
		send_ticks(1);
		drive_beat(make_beat(FUNC_STOP_STAND));
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		load_standing({"4", "3", "2", "1"});
		hold_seq <= hold_seq + 1;
		send_ticks(40);
		drive_beat(make_beat(FUNC_STOP_STAND));
	endtask

	task automatic test_repeat_scroll();
		write_char(0, "H");
		write_char(1, "i");
		write_char(2, "-");
		write_char(3, "*");
		start_roll(1, 0);
		load_standing({"A", "B", "C", "D"});
		write_char(5, "x");
		start_roll(10, 1);
		send_ticks((1 + PAD) * SCROLL_TICKS + 40);
		drive_beat(make_beat(FUNC_STOP_REP));
		tick_until_scroll_done();
		send_ticks(2);
	endtask

	task automatic test_random_traffic(input int count);
		item_t b;
		int    pick;
		int    len_pick;
		repeat (count) begin
			pick = $urandom_range(99);
			if (rolling_on) begin
				if (pick < 88)
					b = make_beat(FUNC_TICK);
				else if (pick < 90)
					b = make_beat(FUNC_STOP_REP);
				else
					b = make_beat(3'($urandom_range(7)));
			end else begin
				if (pick < 30)
					b = make_beat(FUNC_TICK);
				else if (pick < 40)
					b = make_beat(FUNC_LOAD_STAND);
				else if (pick < (standing_on ? 55 : 45))
					b = make_beat(FUNC_STOP_STAND);
				else if (pick < 70)
					b = make_beat(FUNC_WRITE_CHAR);
				else if (pick < 85) begin
					b = make_beat(FUNC_START_ROLL);
					len_pick = $urandom_range(99);
					if (len_pick < 80)
						b.text_length = 7'($urandom_range(3));
					else if (len_pick < 92)
						b.text_length = 7'($urandom_range(127, MAX_TEXT));
					else
						b.text_length = 7'($urandom_range(15, 4));
				end else if (pick < 95)
					b = make_beat(FUNC_STOP_REP);
				else
					b = make_beat(3'($urandom_range(7)));
			end
			drive_beat(b);
		end
	endtask

	task automatic test_longest_text();
		drive_beat(make_beat(FUNC_STOP_REP));
		tick_until_scroll_done();
		write_char(0, ">");
		write_char(62, "7");
		write_char(63, "Y");
		start_roll(MAX_TEXT - 1, 0);
		send_ticks(SCROLL_TICKS);
	endtask

	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			hold_left <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			beats_out++;
			if (due_outputs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result beat with nothing expected: %h", $realtime, result);
			end else begin
				want = due_outputs.pop_front();
				if (result.status !== want.status || result.segments !== want.segments ||
						result.anodes !== want.anodes ||
						result.rolling_busy !== want.rolling_busy ||
						result.standing_busy !== want.standing_busy) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: beat %0d expected st=%0d seg=%h an=%h rb=%0d sb=%0d",
							$realtime, beats_out, want.status, want.segments, want.anodes,
							want.rolling_busy, want.standing_busy);
						$display("    got st=%0d seg=%h an=%h rb=%0d sb=%0d",
							result.status, result.segments, result.anodes,
							result.rolling_busy, result.standing_busy);
					end
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
		$display("FAIL seven_segment_scroll_multiplexer_top");
		$finish;
	end

	initial begin
		for (int k = 0; k < MAX_TEXT; k++)
			disp_store[k] = 8'h00;
		for (int k = 0; k < 4; k++)
			stand_chars[k] = 8'h00;
		rolling_on = 0;
		standing_on = 0;
		repeat_on = 0;
		roll_len = 0;
		roll_pos = 0;
		scan_anode = 4'h1;
		scan_digit = 0;
		scroll_count = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		test_idle_commands();
		test_standing_text();
		test_backpressure();
		test_repeat_scroll();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random_traffic(170);
		send_idle_pct = 59;
		recv_stall_pct = 0;
		test_random_traffic(170);
		send_idle_pct = 0;
		recv_stall_pct = 59;
		test_random_traffic(170);
		send_idle_pct = 21;
		recv_stall_pct = 21;
		test_random_traffic(170);

		test_longest_text();

		item_valid <= 1'b0;
		while (due_outputs.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Ran %0d input beats and %0d result beats through standing, scroll,", beats_in,
			beats_out);
		$display("repeat, busy and error paths; %0d scrolls started, %0d ran to the end.",
			scrolls_started, scrolls_ended);
		if (mismatches == 0 && due_outputs.size() == 0) begin
			$display("PASS seven_segment_scroll_multiplexer_top");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAIL seven_segment_scroll_multiplexer_top");
		end
		$finish;
	end

endmodule

[seven_segment_scroll_multiplexer_top.f]
rtl/core/ssm_pkg.sv
rtl/core/ssm_text_mem.sv
rtl/core/ssm_ctrl.sv
rtl/core/ssm_out.sv
rtl/core/seven_segment_scroll_multiplexer_top.sv
tb/sv/testbench.sv
